// File: rtl/dpq_pkg.sv
// Package for the double-ended priority queue core.
// Holds the sizes, the action and status codes and the controller state type.
// It depends on nothing else.
package dpq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned OccW     = $clog2(Capacity + 1);
  localparam int unsigned NameW    = 24;
  localparam int unsigned PrioW    = 24;
  localparam int unsigned EntryW   = NameW + PrioW;

  localparam logic [1:0] ActInsert  = 2'd0;
  localparam logic [1:0] ActServeHi = 2'd1;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StServed   = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_SERVE
  } state_e;

endpackage

// File: rtl/dpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the entry store of the priority queue core; depends on no package.
module dpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/double_ended_priority_queue_core.sv
// Top level of the double-ended priority queue core.
// Depends on dpq_pkg and on dpq_ram for the entry store.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   action_i selects insert (0), serve highest (1) or serve lowest (2 or 3);
//   client_name_i and priority_req_i matter only for an insert.
//   Each request gives one result on served_name_o and status_o, shown for
//   exactly one cycle with done_o high. The receiver cannot stall it.
//   Flow per request:
//     serve of a non-empty store: the entry is read when the request is
//       taken and registered as the result from the serve state; busy is high in that state.
//     serve of an empty store, or insert into a full store: result in the
//       cycle after the request is taken; busy stays low.
//     insert into a store of n entries that lands k places from the top:
//       the k entries above it are moved up one at a time, since the store
//       has a single read and a single write port, and then the new entry
//       is written (an insert into an empty store gives its result in the cycle after it is taken).
//   Entries live in a circular buffer in ascending priority order; serving
//   the lowest just advances the head pointer. Capacity is a power of two.
//   Reset empties the queue at once; no clearing pass is needed.
module double_ended_priority_queue_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action_i,
  input  logic [dpq_pkg::NameW-1:0] client_name_i,
  input  logic [dpq_pkg::PrioW-1:0] priority_req_i,
  output logic                      done_o,
  output logic [dpq_pkg::NameW-1:0] served_name_o,
  output logic [1:0]                status_o
);

  localparam logic [dpq_pkg::OccW-1:0] CapOcc = dpq_pkg::OccW'(dpq_pkg::Capacity);
  localparam logic [dpq_pkg::OccW-1:0] OneOcc = dpq_pkg::OccW'(1);
  localparam logic [dpq_pkg::OccW-1:0] TwoOcc = dpq_pkg::OccW'(2);

  dpq_pkg::state_e state_q, state_d;

  logic [dpq_pkg::OccW-1:0]  occ_q, occ_d;
  logic [dpq_pkg::AddrW-1:0] head_q, head_d;
  logic [dpq_pkg::OccW-1:0]  pos_q, pos_d;
  logic [dpq_pkg::NameW-1:0] name_q, name_d;
  logic [dpq_pkg::PrioW-1:0] key_q, key_d;
  logic                      done_q, done_d;
  logic [dpq_pkg::NameW-1:0] res_name_q, res_name_d;
  logic [1:0]                res_stat_q, res_stat_d;

  logic                       we;
  logic [dpq_pkg::AddrW-1:0]  waddr, raddr;
  logic [dpq_pkg::EntryW-1:0] wdata, rdata;
  logic [dpq_pkg::PrioW-1:0]  rd_prio;
  logic [dpq_pkg::NameW-1:0]  rd_name;
  logic                       accept;

  // Logical place within the queue to physical RAM address.
  function automatic logic [dpq_pkg::AddrW-1:0] phys(
    input logic [dpq_pkg::AddrW-1:0] head,
    input logic [dpq_pkg::OccW-1:0]  lpos
  );
    logic [dpq_pkg::OccW:0] sum;
    sum = {2'b00, head} + {1'b0, lpos};
    if (sum >= (dpq_pkg::OccW + 1)'(dpq_pkg::Capacity)) begin
      sum = sum - (dpq_pkg::OccW + 1)'(dpq_pkg::Capacity);
    end
    return sum[dpq_pkg::AddrW-1:0];
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state_q != dpq_pkg::S_IDLE);
  assign rd_prio = rdata[dpq_pkg::EntryW-1:dpq_pkg::NameW];
  assign rd_name = rdata[dpq_pkg::NameW-1:0];

  dpq_ram #(
    .Width(dpq_pkg::EntryW),
    .Depth(dpq_pkg::Capacity)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          if (action_i == dpq_pkg::ActInsert) begin
            if (occ_q != '0 && occ_q != CapOcc) begin
              state_d = dpq_pkg::S_INS_CMP;
            end
          end else if (occ_q != '0) begin
            state_d = dpq_pkg::S_SERVE;
          end
        end
      end
      dpq_pkg::S_INS_CMP: begin
        if (rd_prio > key_q) begin
          if (pos_q == OneOcc) begin
            state_d = dpq_pkg::S_INS_WR;
          end
        end else begin
          state_d = dpq_pkg::S_IDLE;
        end
      end
      dpq_pkg::S_INS_WR: state_d = dpq_pkg::S_IDLE;
      dpq_pkg::S_SERVE:  state_d = dpq_pkg::S_IDLE;
      default:           state_d = dpq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    occ_d      = occ_q;
    head_d     = head_q;
    pos_d      = pos_q;
    name_d     = name_q;
    key_d      = key_q;
    done_d     = 1'b0;
    res_name_d = res_name_q;
    res_stat_d = res_stat_q;
    we         = 1'b0;
    waddr      = phys(head_q, pos_q);
    wdata      = {key_q, name_q};
    raddr      = phys(head_q, pos_q - OneOcc);
    case (state_q)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          name_d = client_name_i;
          key_d  = priority_req_i;
          pos_d  = occ_q;
          raddr  = phys(head_q, occ_q - OneOcc);
          case (action_i)
            dpq_pkg::ActInsert: begin
              if (occ_q == CapOcc) begin
                done_d     = 1'b1;
                res_name_d = '0;
                res_stat_d = dpq_pkg::StFull;
              end else if (occ_q == '0) begin
                we         = 1'b1;
                waddr      = head_q;
                wdata      = {priority_req_i, client_name_i};
                occ_d      = OneOcc;
                done_d     = 1'b1;
                res_name_d = '0;
                res_stat_d = dpq_pkg::StInserted;
              end
            end
            dpq_pkg::ActServeHi: begin
              if (occ_q == '0) begin
                done_d     = 1'b1;
                res_name_d = '0;
                res_stat_d = dpq_pkg::StEmpty;
              end else begin
                occ_d = occ_q - OneOcc;
              end
            end
            default: begin
              if (occ_q == '0) begin
                done_d     = 1'b1;
                res_name_d = '0;
                res_stat_d = dpq_pkg::StEmpty;
              end else begin
                raddr  = head_q;
                head_d = head_q + dpq_pkg::AddrW'(1);
                occ_d  = occ_q - OneOcc;
              end
            end
          endcase
        end
      end
      dpq_pkg::S_INS_CMP: begin
        we = 1'b1;
        if (rd_prio > key_q) begin
          // Shift the larger entry up one place and look at the next one down.
          wdata = rdata;
          pos_d = pos_q - OneOcc;
          raddr = phys(head_q, pos_q - TwoOcc);
        end else begin
          occ_d      = occ_q + OneOcc;
          done_d     = 1'b1;
          res_name_d = '0;
          res_stat_d = dpq_pkg::StInserted;
        end
      end
      dpq_pkg::S_INS_WR: begin
        we         = 1'b1;
        occ_d      = occ_q + OneOcc;
        done_d     = 1'b1;
        res_name_d = '0;
        res_stat_d = dpq_pkg::StInserted;
      end
      dpq_pkg::S_SERVE: begin
        done_d     = 1'b1;
        res_name_d = rd_name;
        res_stat_d = dpq_pkg::StServed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpq_pkg::S_IDLE;
      occ_q   <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    name_q     <= name_d;
    key_q      <= key_d;
    res_name_q <= res_name_d;
    res_stat_q <= res_stat_d;
  end

  assign done_o        = done_q;
  assign served_name_o = res_name_q;
  assign status_o      = res_stat_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CapOcc)
    else $error("occupancy above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == dpq_pkg::ActInsert && occ_q == CapOcc)
      |=> (done_o && status_o == dpq_pkg::StFull && $stable(occ_q)))
    else $error("insert into a full store not dropped");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpq_pkg::S_INS_CMP) |-> (pos_q != '0 && pos_q <= occ_q))
    else $error("insert position out of range");

endmodule
